// ===== design/hba_pkg.sv =====
// ----------------------------------------------------------------------------
// hba_pkg
// types, constants and helpers of the hybrid burst assembler
// ----------------------------------------------------------------------------
package hba_pkg;

    localparam int NUM_DEST_DEF = 4;
    localparam int NUM_CLASS    = 3;

    localparam int LIM_W   = 20;
    localparam int BYTES_W = 24;
    localparam int PKTS_W  = 16;
    localparam int NUM_W   = 32;
    localparam int PB_W    = 16;

    localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};
    localparam logic [PKTS_W-1:0]  PKTS_MAX  = {PKTS_W{1'b1}};

    localparam logic [5:0] DSCP_VOICE = 6'd46;
    localparam logic [5:0] DSCP_VIDEO = 6'd34;

    localparam logic [1:0] SVC_VOICE = 2'd0;
    localparam logic [1:0] SVC_DATA  = 2'd1;
    localparam logic [1:0] SVC_VIDEO = 2'd2;

    localparam logic MODE_ARRIVAL = 1'b0;
    localparam logic MODE_TICK    = 1'b1;

    localparam logic CUT_LENGTH = 1'b0;
    localparam logic CUT_TIMER  = 1'b1;

    localparam logic [2:0] REG_LEN_VOICE  = 3'd0;
    localparam logic [2:0] REG_LEN_DATA   = 3'd1;
    localparam logic [2:0] REG_LEN_VIDEO  = 3'd2;
    localparam logic [2:0] REG_TIME_VOICE = 3'd3;
    localparam logic [2:0] REG_TIME_DATA  = 3'd4;
    localparam logic [2:0] REG_TIME_VIDEO = 3'd5;

    localparam logic [LIM_W-1:0] LEN_VOICE_RST  = 20'd4000;
    localparam logic [LIM_W-1:0] LEN_DATA_RST   = 20'd8000;
    localparam logic [LIM_W-1:0] LEN_VIDEO_RST  = 20'd6000;
    localparam logic [LIM_W-1:0] TIME_VOICE_RST = 20'd500;
    localparam logic [LIM_W-1:0] TIME_DATA_RST  = 20'd1000;
    localparam logic [LIM_W-1:0] TIME_VIDEO_RST = 20'd750;

    typedef struct packed {
        logic [BYTES_W-1:0] bytes;
        logic [PKTS_W-1:0]  pkts;
        logic [LIM_W-1:0]   left;
        logic               on;
    } unit_t;

    localparam int UNIT_W = $bits(unit_t);

    typedef struct packed {
        logic [1:0]         dest;
        logic [1:0]         svc;
        logic [BYTES_W-1:0] bytes;
        logic [PKTS_W-1:0]  pkts;
        logic               reason;
        logic [NUM_W-1:0]   number;
    } burst_t;

    function automatic logic [1:0] service_of(input logic [5:0] dscp);
        logic [1:0] s;
        s = SVC_DATA;
        if (dscp == DSCP_VOICE)
        begin
            s = SVC_VOICE;
        end
        else if (dscp == DSCP_VIDEO)
        begin
            s = SVC_VIDEO;
        end
        return s;
    endfunction

endpackage

// ===== design/hba_ram.sv =====
// ----------------------------------------------------------------------------
// hba_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module hba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/hybrid_burst_assembler.sv =====
// ----------------------------------------------------------------------------
// hybrid_burst_assembler
// timer and length hybrid burst assembly per destination and class
// ----------------------------------------------------------------------------
// input channel (in_valid/in_ready) carries packet arrivals (mode 0) and
// time ticks (mode 1); output channel (out_valid/out_ready) carries bursts,
// last_burst marks the final burst of one input transfer.
// unit state sits in one ram; a small sequencer reads a unit, updates it
// and writes it back through one shared datapath.
// arrival: the unit is read, updated and written back; a burst is pushed
// when nonzero bytes hit or exceed the limit, and when they exceed it the
// packet share is found first (one 16x20 multiply, then a 16-step
// restoring divider). tick: NUM_DEST*3 units walked in order; an expiring
// unit that holds bytes also pushes a burst.
// one finished burst waits in a holding register while the walk goes on;
// when the receiver stalls and both output and holding register are full,
// the walk stops until a transfer frees room. in_ready is low while busy.
// after reset a clearing pass writes zero to every unit with in_ready low;
// configuration writes are taken at any time.
// config registers sit on an apb port at byte address 4*index.
// ----------------------------------------------------------------------------
module hybrid_burst_assembler
    import hba_pkg::*;
#(
    parameter int NUM_DEST = NUM_DEST_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                mode,
    input  logic [1:0]          dest_node,
    input  logic [5:0]          dscp_code,
    input  logic [PB_W-1:0]     packet_bytes,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          burst_dest,
    output logic [1:0]          burst_service,
    output logic [BYTES_W-1:0]  burst_bytes,
    output logic [PKTS_W-1:0]   burst_packets,
    output logic                cut_reason,
    output logic [NUM_W-1:0]    burst_number,
    output logic                last_burst
);

    localparam int NUM_UNITS = NUM_DEST * NUM_CLASS;
    localparam int UW        = $clog2(NUM_UNITS);
    localparam int DW        = (NUM_DEST > 1) ? $clog2(NUM_DEST) : 1;

    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_RD   = 4'd2;
    localparam logic [3:0] ST_PROC = 4'd3;
    localparam logic [3:0] ST_MUL  = 4'd4;
    localparam logic [3:0] ST_DIV  = 4'd5;
    localparam logic [3:0] ST_DFIN = 4'd6;
    localparam logic [3:0] ST_PUSH = 4'd7;
    localparam logic [3:0] ST_NEXT = 4'd8;
    localparam logic [3:0] ST_FIN  = 4'd9;

    // configuration
    logic [LIM_W-1:0] len_reg  [NUM_CLASS];
    logic [LIM_W-1:0] time_reg [NUM_CLASS];
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg[0]  <= LEN_VOICE_RST;
            len_reg[1]  <= LEN_DATA_RST;
            len_reg[2]  <= LEN_VIDEO_RST;
            time_reg[0] <= TIME_VOICE_RST;
            time_reg[1] <= TIME_DATA_RST;
            time_reg[2] <= TIME_VIDEO_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_LEN_VOICE:  len_reg[0]  <= pwdata[LIM_W-1:0];
                REG_LEN_DATA:   len_reg[1]  <= pwdata[LIM_W-1:0];
                REG_LEN_VIDEO:  len_reg[2]  <= pwdata[LIM_W-1:0];
                REG_TIME_VOICE: time_reg[0] <= pwdata[LIM_W-1:0];
                REG_TIME_DATA:  time_reg[1] <= pwdata[LIM_W-1:0];
                REG_TIME_VIDEO: time_reg[2] <= pwdata[LIM_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[4:2])
            REG_LEN_VOICE:  prdata = 32'(len_reg[0]);
            REG_LEN_DATA:   prdata = 32'(len_reg[1]);
            REG_LEN_VIDEO:  prdata = 32'(len_reg[2]);
            REG_TIME_VOICE: prdata = 32'(time_reg[0]);
            REG_TIME_DATA:  prdata = 32'(time_reg[1]);
            REG_TIME_VIDEO: prdata = 32'(time_reg[2]);
            default:        prdata = '0;
        endcase
    end

    // sequencer state
    logic [3:0]          state_reg, state_next;
    logic [UW-1:0]       idx_reg, idx_next;
    logic [DW-1:0]       dest_reg, dest_next;
    logic [1:0]          svc_reg, svc_next;
    logic                mode_reg, mode_next;
    logic [PB_W-1:0]     pb_reg, pb_next;
    logic [BYTES_W-1:0]  w_sum_reg, w_sum_next;
    logic [PKTS_W-1:0]   w_pk_reg, w_pk_next;
    logic [LIM_W-1:0]    w_left_reg, w_left_next;
    logic [BYTES_W-1:0]  rem_reg, rem_next;
    logic [PKTS_W-1:0]   q_reg, q_next;
    logic [3:0]          cnt_reg, cnt_next;
    burst_t              nb_reg, nb_next;
    burst_t              pend_reg, pend_next;
    logic                pend_valid_reg, pend_valid_next;
    burst_t              out_reg, out_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_last_reg, out_last_next;
    logic [NUM_W-1:0]    counter_reg, counter_next;

    // ram port
    logic                we;
    unit_t               wdata;
    unit_t               rdata;
    logic [UNIT_W-1:0]   rdata_raw;

    hba_ram #(
        .WIDTH (UNIT_W),
        .DEPTH (NUM_UNITS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (idx_reg),
        .wdata (wdata),
        .raddr (idx_reg),
        .rdata (rdata_raw)
    );

    assign rdata = unit_t'(rdata_raw);

    // datapath
    logic [LIM_W-1:0]    lim;
    logic [LIM_W-1:0]    tl;
    logic [BYTES_W-1:0]  lim_b;
    logic [BYTES_W:0]    sum_w;
    logic [BYTES_W-1:0]  sum;
    logic [PKTS_W-1:0]   pk;
    logic                on1;
    logic [LIM_W-1:0]    left1;
    logic [35:0]         prod;
    logic [BYTES_W:0]    trial;
    logic                ge;
    logic [PKTS_W-1:0]   p;
    logic [PKTS_W-1:0]   left_pk;
    logic                out_free;
    logic                push_ok;
    logic                in_fire;
    logic [1:0]          in_svc;

    assign lim      = len_reg[svc_reg];
    assign tl       = time_reg[svc_reg];
    assign lim_b    = BYTES_W'(lim);
    assign sum_w    = {1'b0, rdata.bytes} + (BYTES_W+1)'(pb_reg);
    assign sum      = sum_w[BYTES_W] ? BYTES_MAX : sum_w[BYTES_W-1:0];
    assign pk       = (rdata.pkts == PKTS_MAX) ? PKTS_MAX : rdata.pkts + 1'b1;
    assign on1      = ((pk == PKTS_W'(1)) && !rdata.on) ? 1'b1 : rdata.on;
    assign left1    = ((pk == PKTS_W'(1)) && !rdata.on) ? tl : rdata.left;
    assign prod     = 36'(w_pk_reg) * 36'(lim);
    assign trial    = {rem_reg, q_reg[PKTS_W-1]};
    assign ge       = trial >= {1'b0, w_sum_reg};
    assign p        = (q_reg == '0) ? PKTS_W'(1) : q_reg;
    assign left_pk  = (w_pk_reg > p) ? w_pk_reg - p : '0;
    assign out_free = !out_valid_reg || out_ready;
    assign push_ok  = !pend_valid_reg || out_free;
    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign in_svc   = service_of(dscp_code);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        dest_next       = dest_reg;
        svc_next        = svc_reg;
        mode_next       = mode_reg;
        pb_next         = pb_reg;
        w_sum_next      = w_sum_reg;
        w_pk_next       = w_pk_reg;
        w_left_next     = w_left_reg;
        rem_next        = rem_reg;
        q_next          = q_reg;
        cnt_next        = cnt_reg;
        nb_next         = nb_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_last_next   = out_last_reg;
        counter_next    = counter_reg;
        we              = 1'b0;
        wdata           = '0;

        unique case (state_reg)
            ST_CLR:
            begin
                we = 1'b1;
                if (idx_reg == UW'(NUM_UNITS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    mode_next = mode;
                    pb_next   = packet_bytes;
                    if (mode == MODE_TICK)
                    begin
                        idx_next   = '0;
                        dest_next  = '0;
                        svc_next   = SVC_VOICE;
                        state_next = ST_RD;
                    end
                    else if (32'(dest_node) < NUM_DEST)
                    begin
                        idx_next   = UW'(32'(dest_node) * NUM_CLASS + 32'(in_svc));
                        dest_next  = DW'(dest_node);
                        svc_next   = in_svc;
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_PROC;
            end
            ST_PROC:
            begin
                state_next = ST_NEXT;
                nb_next.dest = 2'(dest_reg);
                nb_next.svc  = svc_reg;
                if (mode_reg == MODE_ARRIVAL)
                begin
                    nb_next.reason = CUT_LENGTH;
                    if (sum >= lim_b)
                    begin
                        if (sum == '0)
                        begin
                            we    = 1'b1;
                            wdata = '{bytes: '0, pkts: pk, left: left1, on: 1'b0};
                        end
                        else if (sum > lim_b)
                        begin
                            w_sum_next  = sum;
                            w_pk_next   = pk;
                            w_left_next = left1;
                            state_next  = ST_MUL;
                        end
                        else
                        begin
                            we    = 1'b1;
                            wdata = '{bytes: '0, pkts: '0, left: left1, on: 1'b0};
                            nb_next.bytes = sum;
                            nb_next.pkts  = pk;
                            state_next    = ST_PUSH;
                        end
                    end
                    else
                    begin
                        we    = 1'b1;
                        wdata = '{bytes: sum, pkts: pk, left: left1, on: on1};
                    end
                end
                else if (rdata.on)
                begin
                    we             = 1'b1;
                    nb_next.reason = CUT_TIMER;
                    if (rdata.left > LIM_W'(1))
                    begin
                        wdata = '{bytes: rdata.bytes, pkts: rdata.pkts,
                                  left: rdata.left - 1'b1, on: 1'b1};
                    end
                    else if (rdata.bytes == '0)
                    begin
                        wdata = '{bytes: '0, pkts: rdata.pkts, left: '0, on: 1'b0};
                    end
                    else
                    begin
                        wdata         = '0;
                        nb_next.bytes = rdata.bytes;
                        nb_next.pkts  = rdata.pkts;
                        state_next    = ST_PUSH;
                    end
                end
            end
            ST_MUL:
            begin
                rem_next   = BYTES_W'(prod[35:16]);
                q_next     = prod[15:0];
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = ge ? BYTES_W'(trial - {1'b0, w_sum_reg}) : trial[BYTES_W-1:0];
                q_next   = {q_reg[PKTS_W-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 4'd15)
                begin
                    state_next = ST_DFIN;
                end
            end
            ST_DFIN:
            begin
                we    = 1'b1;
                wdata = '{bytes: w_sum_reg - lim_b, pkts: left_pk,
                          left: (left_pk != '0) ? tl : w_left_reg,
                          on: (left_pk != '0)};
                nb_next.bytes = lim_b;
                nb_next.pkts  = p;
                state_next    = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (push_ok)
                begin
                    if (pend_valid_reg)
                    begin
                        out_next       = pend_reg;
                        out_valid_next = 1'b1;
                        out_last_next  = 1'b0;
                    end
                    pend_next        = nb_reg;
                    pend_next.number = counter_reg;
                    pend_valid_next  = 1'b1;
                    counter_next     = counter_reg + 1'b1;
                    state_next       = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if ((mode_reg == MODE_TICK) && (idx_reg != UW'(NUM_UNITS - 1)))
                begin
                    idx_next = idx_reg + 1'b1;
                    if (svc_reg == SVC_VIDEO)
                    begin
                        svc_next  = SVC_VOICE;
                        dest_next = dest_reg + 1'b1;
                    end
                    else
                    begin
                        svc_next = svc_reg + 1'b1;
                    end
                    state_next = ST_RD;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_next        = pend_reg;
                    out_valid_next  = 1'b1;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLR;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            counter_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            counter_reg    <= counter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dest_reg     <= dest_next;
        svc_reg      <= svc_next;
        mode_reg     <= mode_next;
        pb_reg       <= pb_next;
        w_sum_reg    <= w_sum_next;
        w_pk_reg     <= w_pk_next;
        w_left_reg   <= w_left_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        cnt_reg      <= cnt_next;
        nb_reg       <= nb_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid     = out_valid_reg;
    assign burst_dest    = out_reg.dest;
    assign burst_service = out_reg.svc;
    assign burst_bytes   = out_reg.bytes;
    assign burst_packets = out_reg.pkts;
    assign cut_reason    = out_reg.reason;
    assign burst_number  = out_reg.number;
    assign last_burst    = out_last_reg;

    // no burst is left behind when a new transfer is taken
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !pend_valid_reg)
        else $error("holding register full while ready");

    // divider remainder stays below the divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < w_sum_reg))
        else $error("divider remainder out of range");

    // each burst taken into the holding register advances the sequence number
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_PUSH) && push_ok) |=> (counter_reg == $past(counter_reg) + 1'b1))
        else $error("burst number did not advance");

    // the last burst of a transfer leaves the holding register empty
    a_last_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && out_last_reg |-> !pend_valid_reg)
        else $error("last burst with another burst pending");

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// burst assembler check: random arrivals and ticks against a local predictor
// ----------------------------------------------------------------------------
// arrivals and ticks go in through a queue-fed driver; every burst transfer
// is compared field by field with the oldest predicted burst. the receiver
// stalls on its own pattern, once for a long stretch. limits are rewritten
// between phases while the block is idle, extremes included.
// ----------------------------------------------------------------------------
module tb_top;
    import hba_pkg::*;

    localparam int NUNITS = NUM_DEST_DEF * NUM_CLASS;

    typedef struct packed {
        logic            mode;
        logic [1:0]      dest;
        logic [5:0]      dscp;
        logic [PB_W-1:0] pbytes;
    } pkt_item_t;

    typedef struct packed {
        burst_t burst;
        logic   last;
    } burst_exp_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic in_valid, in_ready;
    logic mode;
    logic [1:0] dest_node;
    logic [5:0] dscp_code;
    logic [PB_W-1:0] packet_bytes;
    logic out_valid, out_ready;
    logic [1:0] burst_dest, burst_service;
    logic [BYTES_W-1:0] burst_bytes;
    logic [PKTS_W-1:0] burst_packets;
    logic cut_reason;
    logic [NUM_W-1:0] burst_number;
    logic last_burst;

    hybrid_burst_assembler dut (.*);

    // predictor state
    logic [LIM_W-1:0]   len_lim [3];
    logic [LIM_W-1:0]   time_lim [3];
    logic [BYTES_W-1:0] acc_bytes [NUNITS];
    logic [PKTS_W-1:0]  acc_pkts [NUNITS];
    logic [LIM_W-1:0]   timer_left [NUNITS];
    logic               timer_on [NUNITS];
    logic [NUM_W-1:0]   seq_num;

    pkt_item_t  pending_items[$];
    burst_exp_t expected_bursts[$];
    int mismatches = 0;
    int sent_count = 0;
    int hold_cycles = 0;
    bit hold_start = 1'b0;
    bit hold_taken = 1'b0;
    bit burst_mode;
    int burst_left;
    int gap_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [1:0] class_of(logic [5:0] dscp);
        if (dscp == DSCP_VOICE)
            return SVC_VOICE;
        if (dscp == DSCP_VIDEO)
            return SVC_VIDEO;
        return SVC_DATA;
    endfunction

    function automatic void emit_burst(int u, logic [BYTES_W-1:0] b,
                                       logic [PKTS_W-1:0] p, logic why);
        burst_exp_t e;
        e.burst.dest   = 2'(u / NUM_CLASS);
        e.burst.svc    = 2'(u % NUM_CLASS);
        e.burst.bytes  = b;
        e.burst.pkts   = p;
        e.burst.reason = why;
        e.burst.number = seq_num;
        e.last         = 1'b0;
        seq_num = seq_num + 1'b1;
        expected_bursts = {expected_bursts, e};
    endfunction

    function automatic void predict_bursts(pkt_item_t it);
        int u, n0;
        logic [1:0] svc;
        logic [LIM_W-1:0] lim;
        logic [25:0] sum;
        logic [BYTES_W-1:0] b;
        logic [PKTS_W-1:0] p;
        logic [63:0] q;
        n0 = expected_bursts.size();
        if (it.mode == MODE_ARRIVAL)
        begin
            svc = class_of(it.dscp);
            u = it.dest * NUM_CLASS + svc;
            lim = len_lim[svc];
            sum = acc_bytes[u] + it.pbytes;
            acc_bytes[u] = (sum > BYTES_MAX) ? BYTES_MAX : sum[BYTES_W-1:0];
            if (acc_pkts[u] != PKTS_MAX)
                acc_pkts[u] = acc_pkts[u] + 1'b1;
            if (acc_pkts[u] == 1 && !timer_on[u])
            begin
                timer_on[u] = 1'b1;
                timer_left[u] = time_lim[svc];
            end
            if (acc_bytes[u] >= lim)
            begin
                timer_on[u] = 1'b0;
                if (acc_bytes[u] > 0)
                begin
                    b = acc_bytes[u];
                    p = acc_pkts[u];
                    if (b > lim)
                    begin
                        q = (64'(p) * 64'(lim)) / 64'(b);
                        if (q < 1)
                            q = 64'd1;
                        p = q[PKTS_W-1:0];
                        acc_pkts[u] = (acc_pkts[u] > p) ? acc_pkts[u] - p : '0;
                        b = lim;
                    end
                    else
                        acc_pkts[u] = '0;
                    acc_bytes[u] = acc_bytes[u] - b;
                    emit_burst(u, b, p, CUT_LENGTH);
                    if (acc_pkts[u] > 0 && !timer_on[u])
                    begin
                        timer_on[u] = 1'b1;
                        timer_left[u] = time_lim[svc];
                    end
                end
            end
        end
        else
        begin
            for (u = 0; u < NUNITS; u++)
            begin
                if (!timer_on[u])
                    continue;
                if (timer_left[u] > 1)
                begin
                    timer_left[u] = timer_left[u] - 1'b1;
                    continue;
                end
                timer_left[u] = '0;
                timer_on[u] = 1'b0;
                if (acc_bytes[u] == 0)
                    continue;
                emit_burst(u, acc_bytes[u], acc_pkts[u], CUT_TIMER);
                acc_bytes[u] = '0;
                acc_pkts[u] = '0;
            end
        end
        if (expected_bursts.size() > n0)
            expected_bursts[$].last = 1'b1;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            mode         <= MODE_ARRIVAL;
            dest_node    <= '0;
            dscp_code    <= '0;
            packet_bytes <= '0;
            burst_left   <= 0;
            gap_left     <= 0;
        end
        else
        begin
            automatic bit fire = in_valid && in_ready;
            if (fire)
            begin
                predict_bursts(pending_items[0]);
                pending_items.delete(0);
                sent_count <= sent_count + 1;
            end
            if (in_valid && !fire)
                ;
            else if (pending_items.size() > 0 && burst_left > 0)
            begin
                in_valid     <= 1'b1;
                mode         <= pending_items[0].mode;
                dest_node    <= pending_items[0].dest;
                dscp_code    <= pending_items[0].dscp;
                packet_bytes <= pending_items[0].pbytes;
                burst_left   <= burst_left - 1;
            end
            else
            begin
                in_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 20);
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_start && !hold_taken)
        begin
            out_ready   <= 1'b0;
            hold_cycles <= 3000;
            hold_taken  <= 1'b1;
        end
        else if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_ready <= ($urandom_range(0, 3) != 0) || burst_mode;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bursts.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected burst: number %0d", burst_number);
            end
            else
            begin
                automatic burst_exp_t e = expected_bursts[0];
                expected_bursts.delete(0);
                if (burst_dest !== e.burst.dest || burst_service !== e.burst.svc ||
                    burst_bytes !== e.burst.bytes || burst_packets !== e.burst.pkts ||
                    cut_reason !== e.burst.reason || burst_number !== e.burst.number ||
                    last_burst !== e.last)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                    begin
                        $write("burst mismatch: exp %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                            e.burst.dest, e.burst.svc, e.burst.bytes, e.burst.pkts,
                            e.burst.reason, e.burst.number, e.last);
                        $display(" got %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                            burst_dest, burst_service, burst_bytes, burst_packets,
                            cut_reason, burst_number, last_burst);
                    end
                end
            end
        end
    end

    task automatic write_limit(logic [2:0] idx, logic [LIM_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < REG_TIME_VOICE)
            len_lim[idx] = val;
        else
            time_lim[idx - REG_TIME_VOICE] = val;
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || in_valid || expected_bursts.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic add_item(logic m, logic [1:0] d, logic [5:0] c, logic [PB_W-1:0] b);
        pkt_item_t it;
        it.mode = m;
        it.dest = d;
        it.dscp = c;
        it.pbytes = b;
        pending_items = {pending_items, it};
    endtask

    function automatic logic [5:0] pick_dscp();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0)
            return DSCP_VOICE;
        if (r == 1)
            return DSCP_VIDEO;
        return 6'($urandom_range(0, 63));
    endfunction

    task automatic random_phase(int n, int max_bytes, int tick_pct);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < tick_pct)
                add_item(MODE_TICK, 2'($urandom), 6'($urandom), 16'($urandom));
            else if ($urandom_range(0, 19) == 0)
                add_item(MODE_ARRIVAL, 2'($urandom), pick_dscp(), 16'($urandom));
            else
                add_item(MODE_ARRIVAL, 2'($urandom), pick_dscp(),
                         16'($urandom_range(0, max_bytes)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        seq_num = '0;
        len_lim[0] = LEN_VOICE_RST; len_lim[1] = LEN_DATA_RST; len_lim[2] = LEN_VIDEO_RST;
        time_lim[0] = TIME_VOICE_RST; time_lim[1] = TIME_DATA_RST;
        time_lim[2] = TIME_VIDEO_RST;
        for (int u = 0; u < NUNITS; u++)
        begin
            acc_bytes[u] = '0; acc_pkts[u] = '0; timer_left[u] = '0; timer_on[u] = 1'b0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset limits
        add_item(MODE_ARRIVAL, 2'd0, DSCP_VOICE, 16'd0);
        add_item(MODE_ARRIVAL, 2'd3, DSCP_VIDEO, 16'hFFFF);
        add_item(MODE_ARRIVAL, 2'd1, 6'd63, 16'd8000);
        add_item(MODE_ARRIVAL, 2'd2, 6'd0, 16'd100);
        add_item(MODE_ARRIVAL, 2'd2, 6'd0, 16'd7900);
        add_item(MODE_TICK, 2'd3, 6'd63, 16'hFFFF);
        drain();

        // short timers, including zero and one
        write_limit(REG_TIME_VOICE, 20'd0);
        write_limit(REG_TIME_DATA, 20'd1);
        write_limit(REG_TIME_VIDEO, 20'd2);
        write_limit(REG_LEN_VOICE, 20'd0);
        add_item(MODE_ARRIVAL, 2'd1, DSCP_VOICE, 16'd0);
        add_item(MODE_ARRIVAL, 2'd1, DSCP_VOICE, 16'd50);
        add_item(MODE_ARRIVAL, 2'd0, 6'd1, 16'd10);
        add_item(MODE_ARRIVAL, 2'd0, DSCP_VIDEO, 16'd0);
        add_item(MODE_ARRIVAL, 2'd0, DSCP_VIDEO, 16'd20);
        add_item(MODE_TICK, 2'd0, 6'd0, 16'd0);
        add_item(MODE_TICK, 2'd0, 6'd0, 16'd0);
        add_item(MODE_TICK, 2'd0, 6'd0, 16'd0);
        drain();

        // small length limits, many packets per cut
        write_limit(REG_LEN_VOICE, 20'd1);
        write_limit(REG_LEN_DATA, 20'd3000);
        write_limit(REG_LEN_VIDEO, 20'd500);
        write_limit(REG_TIME_VOICE, 20'd3);
        write_limit(REG_TIME_DATA, 20'd6);
        write_limit(REG_TIME_VIDEO, 20'd4);
        for (int i = 0; i < 8; i++)
            add_item(MODE_ARRIVAL, 2'd2, 6'd5, 16'd0);
        random_phase(110, 700, 25);
        // long receiver hold-off while items keep coming
        hold_start = 1'b1;
        drain();

        // large byte sums with max limits and long timers
        write_limit(REG_LEN_VOICE, 20'hFFFFF);
        write_limit(REG_LEN_DATA, 20'hFFFFF);
        write_limit(REG_LEN_VIDEO, 20'hFFFFF);
        write_limit(REG_TIME_VOICE, 20'hFFFFF);
        write_limit(REG_TIME_DATA, 20'hFFFFF);
        write_limit(REG_TIME_VIDEO, 20'hFFFFF);
        for (int i = 0; i < 20; i++)
            add_item(MODE_ARRIVAL, 2'd1, DSCP_VIDEO, 16'hFFFF);
        drain();

        // mixed random phases
        write_limit(REG_LEN_VOICE, 20'd2000);
        write_limit(REG_LEN_DATA, 20'd4000);
        write_limit(REG_LEN_VIDEO, 20'd65535);
        write_limit(REG_TIME_VOICE, 20'd5);
        write_limit(REG_TIME_DATA, 20'd8);
        write_limit(REG_TIME_VIDEO, 20'd3);
        burst_mode = 1'b1;
        random_phase(80, 3000, 20);
        drain();
        burst_mode = 1'b0;
        write_limit(REG_LEN_DATA, 20'd1);
        write_limit(REG_TIME_DATA, 20'd0);
        random_phase(150, 65535, 30);
        drain();

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
